// ===== hw/rtl/tiled_max_with_position_macros.svh =====
// Assertion macros for the tiled maximum RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TILED_MAX_WITH_POSITION_MACROS_SVH
`define TILED_MAX_WITH_POSITION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TMWP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tiled max assertion failed");

// Next-cycle implication, disabled during reset.
`define TMWP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tiled max assertion failed");

`endif

// ===== hw/rtl/tmwp_pkg.sv =====
// Package for the tiled maximum block: sizes, register codes, word types
// and clamping functions. Depends on nothing.
package tmwp_pkg;

   localparam int MAX_TILES   = 16;
   localparam int COORD_BITS  = 12;
   localparam int SIZE_BITS   = COORD_BITS + 1;
   localparam int TILE_BITS   = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
   localparam int TCOUNT_BITS = $clog2(MAX_TILES + 1);
   localparam int PROD_BITS   = 2 * TCOUNT_BITS;

   // Fixed widths of the register file fields.
   localparam int CSR_SIZE_BITS  = 13;
   localparam int CSR_TILES_BITS = 5;
   localparam int CSR_DATA_BITS  = 13;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_TILES_ACROSS = 3'd1,
      CSR_TILES_DOWN   = 3'd2,
      CSR_TILE_WIDTH   = 3'd3,
      CSR_TILE_HEIGHT  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CSR_SIZE_BITS-1:0]  frame_width;
      logic [CSR_TILES_BITS-1:0] tiles_across;
      logic [CSR_TILES_BITS-1:0] tiles_down;
      logic [CSR_SIZE_BITS-1:0]  tile_width;
      logic [CSR_SIZE_BITS-1:0]  tile_height;
   } cfg_type;

   // One tile entry as kept in the band memory.
   typedef struct packed {
      logic [7:0]            value;
      logic [COORD_BITS-1:0] col;
      logic [COORD_BITS-1:0] row;
   } entry_type;

   // A pixel with its position, handed from the position tracker.
   typedef struct packed {
      logic                   in_grid;
      logic                   clear;
      logic                   final_px;
      logic                   last;
      logic [7:0]             pixel;
      logic [COORD_BITS-1:0]  col;
      logic [COORD_BITS-1:0]  row;
      logic [TCOUNT_BITS-1:0] tile_col;
      logic [TCOUNT_BITS-1:0] tile_row;
      logic [7:0]             tile_index;
   } pos_word_type;

   typedef struct packed {
      logic [3:0]  tile_x;
      logic [3:0]  tile_y;
      logic [7:0]  tile_index;
      logic [11:0] max_col;
      logic [11:0] max_row;
      logic [7:0]  peak_value;
      logic        last;
   } result_type;

   // Zero acts as one, anything above 2^COORD_BITS as 2^COORD_BITS.
   function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [CSR_SIZE_BITS-1:0] v);
      int unsigned vi;
      int unsigned lim;
      vi  = int'(v);
      lim = 1 << COORD_BITS;
      if (vi == 0) begin
         vi = 1;
      end else if (vi > lim) begin
         vi = lim;
      end
      return SIZE_BITS'(vi);
   endfunction

   function automatic logic [TCOUNT_BITS-1:0] clamp_tiles(input logic [CSR_TILES_BITS-1:0] v);
      int unsigned vi;
      vi = int'(v);
      if (vi > MAX_TILES) begin
         vi = MAX_TILES;
      end
      return TCOUNT_BITS'(vi);
   endfunction

endpackage

// ===== hw/rtl/tmwp_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Reads return the contents from before a write in the same cycle.
module tmwp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tmwp_pos.sv =====
// Position tracker: frame and tile counters that tag each accepted pixel.
// Depends on tmwp_pkg.
module tmwp_pos import tmwp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [7:0]   pixel,
   input  logic         first_of_frame,
   input  cfg_type      cfg,
   output pos_word_type word
);

   localparam logic [COORD_BITS-1:0]  ROW_MAX  = {COORD_BITS{1'b1}};
   localparam logic [TCOUNT_BITS-1:0] TILE_SAT = TCOUNT_BITS'(MAX_TILES);

   logic [COORD_BITS-1:0]  col_ff, col_in, row_ff, row_in;
   logic [COORD_BITS-1:0]  cit_ff, cit_in, rit_ff, rit_in;
   logic [TCOUNT_BITS-1:0] tcol_ff, tcol_in, trow_ff, trow_in;

   logic [COORD_BITS-1:0]  cur_col, cur_row, cur_cit, cur_rit;
   logic [TCOUNT_BITS-1:0] cur_tcol, cur_trow;
   logic [SIZE_BITS-1:0]   fw, tw, th;
   logic [TCOUNT_BITS-1:0] ta, td;
   logic [PROD_BITS-1:0]   index_wide;

   always_comb begin
      fw = clamp_size(cfg.frame_width);
      tw = clamp_size(cfg.tile_width);
      th = clamp_size(cfg.tile_height);
      ta = clamp_tiles(cfg.tiles_across);
      td = clamp_tiles(cfg.tiles_down);

      // The frame's first pixel restarts every counter before it is used.
      cur_col  = first_of_frame ? '0 : col_ff;
      cur_row  = first_of_frame ? '0 : row_ff;
      cur_cit  = first_of_frame ? '0 : cit_ff;
      cur_rit  = first_of_frame ? '0 : rit_ff;
      cur_tcol = first_of_frame ? '0 : tcol_ff;
      cur_trow = first_of_frame ? '0 : trow_ff;

      index_wide = PROD_BITS'(cur_tcol) * PROD_BITS'(td) + PROD_BITS'(cur_trow);

      word.in_grid    = (cur_tcol < ta) && (cur_trow < td) && (SIZE_BITS'(cur_col) < fw);
      word.clear      = (cur_cit == '0) && (cur_rit == '0);
      word.final_px   = (SIZE_BITS'(cur_cit) == tw - 1'b1) && (SIZE_BITS'(cur_rit) == th - 1'b1);
      word.last       = (cur_tcol == ta - 1'b1) && (cur_trow == td - 1'b1);
      word.pixel      = pixel;
      word.col        = cur_col;
      word.row        = cur_row;
      word.tile_col   = cur_tcol;
      word.tile_row   = cur_trow;
      word.tile_index = index_wide[7:0];

      col_in  = cur_col;
      row_in  = cur_row;
      cit_in  = cur_cit;
      rit_in  = cur_rit;
      tcol_in = cur_tcol;
      trow_in = cur_trow;
      if (SIZE_BITS'(cur_col) + 1'b1 >= fw) begin
         col_in  = '0;
         cit_in  = '0;
         tcol_in = '0;
         if (cur_row < ROW_MAX) begin
            row_in = cur_row + 1'b1;
         end
         if (SIZE_BITS'(cur_rit) + 1'b1 >= th) begin
            rit_in = '0;
            if (cur_trow < TILE_SAT) begin
               trow_in = cur_trow + 1'b1;
            end
         end else begin
            rit_in = cur_rit + 1'b1;
         end
      end else begin
         col_in = cur_col + 1'b1;
         if (SIZE_BITS'(cur_cit) + 1'b1 >= tw) begin
            cit_in = '0;
            if (cur_tcol < TILE_SAT) begin
               tcol_in = cur_tcol + 1'b1;
            end
         end else begin
            cit_in = cur_cit + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         cit_ff  <= '0;
         rit_ff  <= '0;
         tcol_ff <= '0;
         trow_ff <= '0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         cit_ff  <= cit_in;
         rit_ff  <= rit_in;
         tcol_ff <= tcol_in;
         trow_ff <= trow_in;
      end
   end

endmodule

// ===== hw/rtl/tmwp_update.sv =====
// Read-modify-write of the band memory with one-deep write forwarding,
// plus the result register. Depends on tmwp_pkg, tmwp_ram and the macros.
`include "tiled_max_with_position_macros.svh"

module tmwp_update import tmwp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  pos_word_type word,
   output logic         ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output result_type   rsp_word
);

   localparam int ENTRY_BITS = $bits(entry_type);

   logic                 s1_valid_ff, s1_valid_in;
   pos_word_type         s1_ff;
   logic                 fwd_valid_ff;
   logic [TILE_BITS-1:0] fwd_addr_ff;
   entry_type            fwd_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_ff;

   logic                 adv;
   logic                 wr_en;
   logic [TILE_BITS-1:0] s1_addr;
   logic [ENTRY_BITS-1:0] rd_raw;
   entry_type            base, updated;
   logic                 better;
   logic                 emit;

   assign s1_addr = s1_ff.tile_col[TILE_BITS-1:0];

   tmwp_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_TILES)
   ) u_band_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr),
      .wr_data (updated),
      .rd_en   (accept),
      .rd_addr (word.tile_col[TILE_BITS-1:0]),
      .rd_data (rd_raw)
   );

   always_comb begin
      // The stage holds only when a tile result waits behind an untaken one.
      adv   = !s1_valid_ff || !s1_ff.final_px || !rsp_valid_ff || rsp_ready;
      ready = adv;
      wr_en = s1_valid_ff && adv;
      emit  = s1_valid_ff && adv && s1_ff.final_px;

      // The read issued alongside the previous write misses it; take it here.
      if (s1_ff.clear) begin
         base = '0;
      end else if (fwd_valid_ff && (fwd_addr_ff == s1_addr)) begin
         base = fwd_data_ff;
      end else begin
         base = entry_type'(rd_raw);
      end

      better = (s1_ff.pixel != 8'd0) &&
               ((s1_ff.pixel > base.value) ||
                ((s1_ff.pixel == base.value) && (s1_ff.col < base.col)));
      updated = base;
      if (better) begin
         updated.value = s1_ff.pixel;
         updated.col   = s1_ff.col;
         updated.row   = s1_ff.row;
      end

      if (accept) begin
         s1_valid_in = word.in_grid;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= word;
      end
      if (wr_en) begin
         fwd_addr_ff <= s1_addr;
         fwd_data_ff <= updated;
      end
      if (emit) begin
         rsp_ff.tile_x     <= 4'(s1_ff.tile_col);
         rsp_ff.tile_y     <= 4'(s1_ff.tile_row);
         rsp_ff.tile_index <= s1_ff.tile_index;
         rsp_ff.max_col    <= 12'(updated.col);
         rsp_ff.max_row    <= 12'(updated.row);
         rsp_ff.peak_value <= updated.value;
         rsp_ff.last       <= s1_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `TMWP_ASSERT_NEXT(a_stall_keeps_entry, clock, reset, s1_valid_ff && !adv, s1_valid_ff && $stable(s1_addr))
   `TMWP_ASSERT_NOW(a_stall_needs_full_out, clock, reset, s1_valid_ff && !adv, rsp_valid_ff && !rsp_ready)
   `TMWP_ASSERT_NEXT(a_result_not_dropped, clock, reset, rsp_valid_ff && !rsp_ready, rsp_valid_ff)

endmodule

// ===== hw/rtl/tiled_max_with_position.sv =====
// Top level of the tiled maximum block: configuration registers, position
// tracker and band memory update. Depends on tmwp_pkg, tmwp_pos, tmwp_update.

// Takes one pixel word per clock in raster order while req_ready is high and
// returns, for every tile of the grid, its largest nonzero pixel with that
// pixel's frame column and row. The best value of each tile column in the
// current band lives in a 16-entry RAM with a registered read; each pixel
// reads its entry when it is accepted, compares and writes it back from the
// stage register, with the last write forwarded to a following pixel of the
// same tile column. A tile's result is registered onto the rsp port when its
// bottom-right pixel leaves the stage register; req_ready drops only while
// a tile result waits behind a result that has not yet been taken. Tile
// entries are cleared on each tile's top-left pixel, so no clearing pass
// follows reset. Registers must only be written while no pixel is in flight.
module tiled_max_with_position import tmwp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_pixel,
   input  logic                      req_first_of_frame,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [3:0]                rsp_tile_x,
   output logic [3:0]                rsp_tile_y,
   output logic [7:0]                rsp_tile_index,
   output logic [11:0]               rsp_max_col,
   output logic [11:0]               rsp_max_row,
   output logic [7:0]                rsp_peak_value,
   output logic                      rsp_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   cfg_type      cfg_ff, cfg_in;
   pos_word_type word;
   result_type   rsp_word;
   logic         accept;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  cfg_in.frame_width  = csr_data[CSR_SIZE_BITS-1:0];
            CSR_TILES_ACROSS: cfg_in.tiles_across = csr_data[CSR_TILES_BITS-1:0];
            CSR_TILES_DOWN:   cfg_in.tiles_down   = csr_data[CSR_TILES_BITS-1:0];
            CSR_TILE_WIDTH:   cfg_in.tile_width   = csr_data[CSR_SIZE_BITS-1:0];
            CSR_TILE_HEIGHT:  cfg_in.tile_height  = csr_data[CSR_SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= CSR_SIZE_BITS'(1280);
         cfg_ff.tiles_across <= CSR_TILES_BITS'(11);
         cfg_ff.tiles_down   <= CSR_TILES_BITS'(11);
         cfg_ff.tile_width   <= CSR_SIZE_BITS'(116);
         cfg_ff.tile_height  <= CSR_SIZE_BITS'(65);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tmwp_pos u_pos (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .pixel          (req_pixel),
      .first_of_frame (req_first_of_frame),
      .cfg            (cfg_ff),
      .word           (word)
   );

   tmwp_update u_update (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .word      (word),
      .ready     (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   assign rsp_tile_x     = rsp_word.tile_x;
   assign rsp_tile_y     = rsp_word.tile_y;
   assign rsp_tile_index = rsp_word.tile_index;
   assign rsp_max_col    = rsp_word.max_col;
   assign rsp_max_row    = rsp_word.max_row;
   assign rsp_peak_value = rsp_word.peak_value;
   assign rsp_last       = rsp_word.last;

endmodule
